@@ rtl/core/mpva_pkg.sv @@
// ----------------------------------------------------------------------------
// mpva_pkg
// Shared opcodes and the structs that pass between the top level and the
// voice cells of the polyphonic MIDI voice allocator.
// ----------------------------------------------------------------------------
package mpva_pkg;

  localparam logic [1:0] OP_NOTE_ON     = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF    = 2'd1;
  localparam logic [1:0] OP_LEARN_START = 2'd2;
  localparam logic [1:0] OP_LEARN_STOP  = 2'd3;

  localparam logic [7:0] NO_CHANNEL = 8'hFF;

  // Command broadcast to every voice cell for the current item.
  typedef struct packed {
    logic       en;
    logic       alloc;
    logic       release_note;
    logic       clear_all;
    logic [6:0] note;
  } cmd_t;

  // Token handed from one cell to the next along the chain.
  typedef struct packed {
    logic       searching;
    logic       hit;
    logic [2:0] which;
  } chain_t;

endpackage

@@ rtl/core/mpva_cell.sv @@
// ----------------------------------------------------------------------------
// mpva_cell
// One voice: holds its gate and note and passes the allocation token on.
// ----------------------------------------------------------------------------
module mpva_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  mpva_pkg::cmd_t   cmd,
  input  mpva_pkg::chain_t chain_in,
  output mpva_pkg::chain_t chain_out,
  output logic            active_next
);
  import mpva_pkg::*;

  logic       active;
  logic [6:0] note;
  logic       take;
  logic       free;

  // The first free cell that sees the search token claims the note.
  assign take = cmd.alloc && chain_in.searching && !active;
  assign free = cmd.release_note && active && (note == cmd.note);

  always_comb begin
    active_next = active;
    if (cmd.clear_all) begin
      active_next = 1'b0;
    end else if (take) begin
      active_next = 1'b1;
    end else if (free) begin
      active_next = 1'b0;
    end
  end

  always_comb begin
    chain_out.searching = chain_in.searching && !take;
    chain_out.hit       = chain_in.hit || take || free;
    chain_out.which     = chain_in.which;
    if (!chain_in.hit && (take || free)) begin
      chain_out.which = 3'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.en) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && take) begin
      note <= cmd.note;
    end
  end

endmodule

@@ rtl/core/midi_poly_voice_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// midi_poly_voice_allocator_unit
// Output: the result is registered and appears in the cycle after the input transfer.
// Throughput: one item per cycle while the output is not stalled; the voice chain settles within that cycle.
// A stalled result stalls the input, and a new item can enter in the same
// cycle as the waiting result transfers.
// Reset: all voices free, no listen channel, base note 0, not learning,
// output register empty.
// ----------------------------------------------------------------------------
module midi_poly_voice_allocator_unit #(
  parameter int VOICES = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [3:0] midi_channel,
  input  logic [6:0] note_number,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] gate_mask,
  output logic [2:0] affected_voice,
  output logic       voice_hit,
  output logic       dropped,
  output logic       learning_now,
  output logic [7:0] listen_channel_out,
  output logic [6:0] base_note_out
);
  import mpva_pkg::*;

  logic       accept;
  logic       learning;
  logic       learning_next;
  logic [7:0] listen_channel;
  logic [7:0] listen_channel_next;
  logic [6:0] base_note;
  logic [6:0] base_note_next;
  logic       chan_match;
  cmd_t       cmd;
  chain_t     chain [VOICES+1];
  logic [7:0] active_vec;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign chan_match = (listen_channel == {4'd0, midi_channel});

  always_comb begin
    cmd.en           = accept;
    cmd.alloc        = (op == OP_NOTE_ON) && !learning && chan_match;
    cmd.release_note = (op == OP_NOTE_OFF) && !learning && chan_match;
    cmd.clear_all    = (op == OP_NOTE_ON) && learning;
    cmd.note         = note_number;
  end

  assign chain[0].searching = cmd.alloc;
  assign chain[0].hit       = 1'b0;
  assign chain[0].which     = 3'd0;

  for (genvar v = 0; v < 8; v++) begin : g_voice
    if (v < VOICES) begin : g_cell
      mpva_cell #(
        .INDEX(v)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .chain_in   (chain[v]),
        .chain_out  (chain[v+1]),
        .active_next(active_vec[v])
      );
    end else begin : g_pad
      assign active_vec[v] = 1'b0;
    end
  end

  always_comb begin
    learning_next       = learning;
    listen_channel_next = listen_channel;
    base_note_next      = base_note;
    case (op)
      OP_NOTE_ON: begin
        if (learning) begin
          learning_next       = 1'b0;
          listen_channel_next = {4'd0, midi_channel};
          base_note_next      = note_number;
        end
      end
      OP_NOTE_OFF:    learning_next = learning;
      OP_LEARN_START: learning_next = 1'b1;
      OP_LEARN_STOP:  learning_next = 1'b0;
      default:        learning_next = learning;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learning       <= 1'b0;
      listen_channel <= NO_CHANNEL;
      base_note      <= 7'd0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        learning       <= learning_next;
        listen_channel <= listen_channel_next;
        base_note      <= base_note_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gate_mask          <= active_vec;
      affected_voice     <= chain[VOICES].which;
      voice_hit          <= chain[VOICES].hit;
      dropped            <= cmd.alloc && chain[VOICES].searching;
      learning_now       <= learning_next;
      listen_channel_out <= listen_channel_next;
      base_note_out      <= base_note_next;
    end
  end

  // A dropped note can only happen when every voice already holds a gate.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> (gate_mask[VOICES-1:0] == {VOICES{1'b1}}) && !voice_hit)
    else $error("dropped note while a voice was free");

  a_idle_voice: assert property (@(posedge clk) disable iff (rst)
    out_valid && !voice_hit |-> affected_voice == 3'd0)
    else $error("affected voice set without a hit");

  a_learn_clear: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.clear_all |=> gate_mask == 8'd0 && !learning_now)
    else $error("learned note-on did not clear voices");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
